// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication: when a holds, b holds on the same edge.
`define ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// Next-cycle implication: when a holds, b holds on the following edge.
`define ASSERT_NXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

// File: rtl/core/sbc_pkg.sv
package sbc_pkg;
   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int RAD_BITS = COORD_BITS - 1;
   localparam int NORM_BITS = NORMAL_FRAC_BITS + 2;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int MAG_BITS = COORD_BITS;
   localparam int SQ_BITS = 2 * MAG_BITS + 2;
   localparam int ROOT_BITS = MAG_BITS + 1;
   localparam int NUM_BITS = MAG_BITS + NORMAL_FRAC_BITS + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX = 2;

   // Classification handed from the front end to the back end.
   typedef enum logic [1:0] {
      KIND_MISS = 2'd0,
      KIND_FACE = 2'd1,
      KIND_NEAR = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic swap;
      logic [RAD_BITS-1:0] radius;
      logic [RAD_BITS-1:0] face_depth;
      logic [1:0] face_axis;
      logic face_min;
      logic [MAG_BITS-1:0] mag_x;
      logic [MAG_BITS-1:0] mag_y;
      logic [MAG_BITS-1:0] mag_z;
      logic pos_x;
      logic pos_y;
      logic pos_z;
   } job_type;

   typedef struct packed {
      logic hit;
      logic [RAD_BITS-1:0] depth;
      logic signed [NORM_BITS-1:0] normal_x;
      logic signed [NORM_BITS-1:0] normal_y;
      logic signed [NORM_BITS-1:0] normal_z;
      logic order_swapped;
   } result_type;
endpackage

// File: rtl/core/sbc_front.sv
module sbc_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] center_x,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] center_y,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] center_z,
   input  logic [sbc_pkg::RAD_BITS-1:0] radius,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] box_min_x,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] box_min_y,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] box_min_z,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] box_max_x,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] box_max_y,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] box_max_z,
   input  logic sphere_mass_zero,
   output logic job_valid,
   input  logic job_ready,
   output sbc_pkg::job_type job
);
   import sbc_pkg::*;

   // Two stages: the first forms per-axis distances, the second picks the face,
   // near-corner or miss case.
   logic s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic s1_ready, s2_ready;
   logic signed [DIFF_BITS-1:0] dl_ff [3], dh_ff [3], dl_in [3], dh_in [3];
   logic [2:0] below_ff, above_ff, below_in, above_in;
   logic [RAD_BITS-1:0] rad_ff, rad_in;
   logic swap_ff, swap_in;
   job_type job_ff, job_in;
   logic signed [COORD_BITS-1:0] c_w [3], lo_w [3], hi_w [3];

   assign c_w = '{center_x, center_y, center_z};
   assign lo_w = '{box_min_x, box_min_y, box_min_z};
   assign hi_w = '{box_max_x, box_max_y, box_max_z};

   assign s2_ready = !s2_valid_ff || job_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dl_in[i] = DIFF_BITS'(c_w[i]) - DIFF_BITS'(lo_w[i]);
         dh_in[i] = DIFF_BITS'(hi_w[i]) - DIFF_BITS'(c_w[i]);
         below_in[i] = c_w[i] < lo_w[i];
         above_in[i] = c_w[i] > hi_w[i];
      end
      rad_in = radius;
      swap_in = sphere_mass_zero;
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   end

   always_comb begin
      logic signed [DIFF_BITS-1:0] m;
      logic signed [DIFF_BITS-1:0] best;
      logic signed [DIFF_BITS-1:0] d;
      logic in_box, near_all;
      logic [MAG_BITS-1:0] mg [3];
      logic pos [3];
      best = '0;
      m = '0;
      d = '0;
      job_in = '0;
      in_box = ((below_ff | above_ff) == 3'b000);
      for (int i = 0; i < 3; i++) begin
         m = (dl_ff[i] <= dh_ff[i]) ? dl_ff[i] : dh_ff[i];
         if (i == 0 || m < best) begin
            best = m;
            job_in.face_axis = 2'(i);
            job_in.face_min = dl_ff[i] <= dh_ff[i];
         end
      end
      near_all = 1'b1;
      for (int i = 0; i < 3; i++) begin
         // Distance past the clamp: center minus the violated bound.
         priority if (below_ff[i]) d = dl_ff[i];
         else if (above_ff[i]) d = -dh_ff[i];
         else d = '0;
         pos[i] = d > 0;
         mg[i] = MAG_BITS'(d < 0 ? -d : d);
         if ((d < 0 ? -d : d) > $signed({2'b00, rad_ff})) near_all = 1'b0;
      end
      job_in.swap = swap_ff;
      job_in.radius = rad_ff;
      job_in.face_depth = rad_ff - RAD_BITS'(best);
      job_in.mag_x = mg[0];
      job_in.mag_y = mg[1];
      job_in.mag_z = mg[2];
      job_in.pos_x = pos[0];
      job_in.pos_y = pos[1];
      job_in.pos_z = pos[2];
      if (in_box) job_in.kind = (best < $signed({2'b00, rad_ff})) ? KIND_FACE : KIND_MISS;
      else job_in.kind = near_all ? KIND_NEAR : KIND_MISS;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_ready && in_valid) begin
         dl_ff <= dl_in;
         dh_ff <= dh_in;
         below_ff <= below_in;
         above_ff <= above_in;
         rad_ff <= rad_in;
         swap_ff <= swap_in;
      end
      if (s2_ready && s1_valid_ff) job_ff <= job_in;
   end

   assign job_valid = s2_valid_ff;
   assign job = job_ff;
endmodule

// File: rtl/core/sbc_queue.sv
module sbc_queue (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  sbc_pkg::job_type push_data,
   output logic pop_valid,
   input  logic pop_ready,
   output sbc_pkg::job_type pop_data
);
   import sbc_pkg::*;

   job_type mem_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_IDX:0] cnt_ff, cnt_in;
   logic push, pop;

   assign push_ready = cnt_ff != (QUEUE_IDX+1)'(QUEUE_DEPTH);
   assign pop_valid = cnt_ff != '0;
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QUEUE_IDX+1)'(push) - (QUEUE_IDX+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule

// File: rtl/core/sbc_back.sv
module sbc_back (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_ready,
   input  sbc_pkg::job_type job,
   output logic res_valid,
   input  logic res_ready,
   output sbc_pkg::result_type res
);
   import sbc_pkg::*;

   // Pipeline: squares, sum, a load stage and ROOT_BITS square-root stages,
   // then three dividers with NORM_BITS+1 stages each, then the result
   // register. Whole pipe moves when its last stage is free.
   localparam int SQRT_ST = ROOT_BITS;
   localparam int DIV_ST = NORMAL_FRAC_BITS + 2;
   localparam int QBITS = DIV_ST;
   localparam int NST = 2 + (SQRT_ST + 1) + (DIV_ST + 1) + 1;

   logic adv;
   logic [NST-1:0] v_ff, v_in;

   assign adv = !v_ff[NST-1] || res_ready;
   assign job_ready = adv;
   assign res_valid = v_ff[NST-1];

   // Stage A: squares.
   job_type ja_ff;
   logic [2*MAG_BITS-1:0] sq_ff [3];
   logic [2*RAD_BITS-1:0] rprod_w;
   // Stage B: sum and r squared.
   job_type jb_ff;
   logic [SQ_BITS-1:0] dsq_ff, rsq_ff;
   // Root stages.
   job_type jr_ff [SQRT_ST+1];
   logic [SQ_BITS-1:0] rv_ff [SQRT_ST+1];
   logic [SQ_BITS-1:0] rr_ff [SQRT_ST+1];
   logic inr_ff [SQRT_ST+1];
   // Divider stages.
   job_type jd_ff [DIV_ST+1];
   logic [ROOT_BITS-1:0] dist_ff [DIV_ST+1];
   logic hit_ff [DIV_ST+1];
   logic [NUM_BITS+1:0] rem_ff [DIV_ST+1][3];
   logic [QBITS-1:0] q_ff [DIV_ST+1][3];
   result_type res_ff, res_in;

   assign rprod_w = ja_ff.radius * ja_ff.radius;

   always_comb begin
      v_in = {v_ff[NST-2:0], job_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ja_ff <= job;
         sq_ff[0] <= job.mag_x * job.mag_x;
         sq_ff[1] <= job.mag_y * job.mag_y;
         sq_ff[2] <= job.mag_z * job.mag_z;
         jb_ff <= ja_ff;
         dsq_ff <= SQ_BITS'(sq_ff[0]) + SQ_BITS'(sq_ff[1]) + SQ_BITS'(sq_ff[2]);
         rsq_ff <= SQ_BITS'(rprod_w);
      end
   end

   // Bit-serial restoring root, one result bit per stage.
   always_ff @(posedge clock) begin
      if (adv) begin
         jr_ff[0] <= jb_ff;
         rv_ff[0] <= dsq_ff;
         rr_ff[0] <= '0;
         inr_ff[0] <= dsq_ff <= rsq_ff;
         for (int s = 0; s < SQRT_ST; s++) begin
            logic [SQ_BITS-1:0] bitv, t;
            bitv = SQ_BITS'(1) << (2 * (SQRT_ST - 1 - s));
            t = rr_ff[s] + bitv;
            jr_ff[s+1] <= jr_ff[s];
            inr_ff[s+1] <= inr_ff[s];
            if (rv_ff[s] >= t) begin
               rv_ff[s+1] <= rv_ff[s] - t;
               rr_ff[s+1] <= (rr_ff[s] >> 1) + bitv;
            end else begin
               rv_ff[s+1] <= rv_ff[s];
               rr_ff[s+1] <= rr_ff[s] >> 1;
            end
         end
      end
   end

   // Rounding, then restoring dividers, one quotient bit per stage.
   always_ff @(posedge clock) begin
      if (adv) begin
         logic [ROOT_BITS-1:0] dround;
         logic [MAG_BITS-1:0] m [3];
         dround = ROOT_BITS'(rr_ff[SQRT_ST]) +
            ROOT_BITS'(rv_ff[SQRT_ST] > rr_ff[SQRT_ST]);
         if (dround == '0) dround = ROOT_BITS'(1);
         m = '{jr_ff[SQRT_ST].mag_x, jr_ff[SQRT_ST].mag_y, jr_ff[SQRT_ST].mag_z};
         jd_ff[0] <= jr_ff[SQRT_ST];
         dist_ff[0] <= dround;
         hit_ff[0] <= inr_ff[SQRT_ST];
         for (int a = 0; a < 3; a++) begin
            rem_ff[0][a] <= (NUM_BITS+2)'({m[a], {NORMAL_FRAC_BITS{1'b0}}})
               + (NUM_BITS+2)'(dround >> 1);
            q_ff[0][a] <= '0;
         end
         for (int s = 0; s < DIV_ST; s++) begin
            jd_ff[s+1] <= jd_ff[s];
            dist_ff[s+1] <= dist_ff[s];
            hit_ff[s+1] <= hit_ff[s];
            for (int a = 0; a < 3; a++) begin
               logic [NUM_BITS+1:0] dv;
               dv = (NUM_BITS+2)'(dist_ff[s]) << (DIV_ST - 1 - s);
               // Quotient bits above the top one only matter as saturation.
               if (rem_ff[s][a] >= dv || (s == 0 && (rem_ff[s][a] >> (DIV_ST - 1))
                     >= (NUM_BITS+2)'(dist_ff[s]))) begin
                  if (s == 0 && (rem_ff[s][a] >> DIV_ST) >= (NUM_BITS+2)'(dist_ff[s]))
                  begin
                     rem_ff[s+1][a] <= '0;
                     q_ff[s+1][a] <= '1;
                  end else begin
                     rem_ff[s+1][a] <= rem_ff[s][a] - dv;
                     q_ff[s+1][a] <= q_ff[s][a] | (QBITS'(1) << (DIV_ST - 1 - s));
                  end
               end else begin
                  rem_ff[s+1][a] <= rem_ff[s][a];
                  q_ff[s+1][a] <= q_ff[s][a];
               end
            end
         end
         res_ff <= res_in;
      end
   end

   always_comb begin
      job_type j;
      logic [QBITS-1:0] q;
      logic signed [NORM_BITS-1:0] nv [3];
      logic pz [3];
      j = jd_ff[DIV_ST];
      pz = '{j.pos_x, j.pos_y, j.pos_z};
      res_in = '0;
      for (int a = 0; a < 3; a++) begin
         q = q_ff[DIV_ST][a];
         if (q > QBITS'(1 << NORMAL_FRAC_BITS)) q = QBITS'(1 << NORMAL_FRAC_BITS);
         nv[a] = pz[a] ? -$signed(NORM_BITS'(q)) : $signed(NORM_BITS'(q));
      end
      unique case (j.kind)
         KIND_FACE: begin
            res_in.hit = 1'b1;
            res_in.depth = j.face_depth;
            res_in.order_swapped = j.swap;
            unique case (j.face_axis)
               2'd0: res_in.normal_x = j.face_min ? -NORM_BITS'(1 << NORMAL_FRAC_BITS)
                  : NORM_BITS'(1 << NORMAL_FRAC_BITS);
               2'd1: res_in.normal_y = j.face_min ? -NORM_BITS'(1 << NORMAL_FRAC_BITS)
                  : NORM_BITS'(1 << NORMAL_FRAC_BITS);
               default: res_in.normal_z = j.face_min ? -NORM_BITS'(1 << NORMAL_FRAC_BITS)
                  : NORM_BITS'(1 << NORMAL_FRAC_BITS);
            endcase
         end
         KIND_NEAR: begin
            if (hit_ff[DIV_ST]) begin
               res_in.hit = 1'b1;
               res_in.depth = (ROOT_BITS'(j.radius) > dist_ff[DIV_ST]) ?
                  RAD_BITS'(ROOT_BITS'(j.radius) - dist_ff[DIV_ST]) : '0;
               res_in.normal_x = nv[0];
               res_in.normal_y = nv[1];
               res_in.normal_z = nv[2];
               res_in.order_swapped = j.swap;
            end
         end
         default: res_in = '0;
      endcase
   end

   assign res = res_ff;
endmodule

// File: rtl/core/sphere_box_contact.sv
// Sphere against axis-aligned box contact. One pair is taken per cycle while
// req_ready is high: each transfer on req_ is classified by a two-stage front
// end (inside-face or near-corner test), queued in a four-entry queue, and
// resolved by a back end that squares and sums the offsets, takes a rounded
// square root with one result bit per stage, and divides each offset by the
// distance with one quotient bit per stage. The root and divider stages make up
// most of the pipeline; throughput is one result per cycle while rsp_ready stays
// high. Coordinates are Q16.16, normals Q1.14.
module sphere_box_contact (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] req_center_x,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] req_center_y,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] req_center_z,
   input  logic [sbc_pkg::RAD_BITS-1:0] req_radius,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] req_box_min_x,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] req_box_min_y,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] req_box_min_z,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] req_box_max_x,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] req_box_max_y,
   input  logic signed [sbc_pkg::COORD_BITS-1:0] req_box_max_z,
   input  logic req_sphere_mass_zero,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_hit,
   output logic [sbc_pkg::RAD_BITS-1:0] rsp_depth,
   output logic signed [sbc_pkg::NORM_BITS-1:0] rsp_normal_x,
   output logic signed [sbc_pkg::NORM_BITS-1:0] rsp_normal_y,
   output logic signed [sbc_pkg::NORM_BITS-1:0] rsp_normal_z,
   output logic rsp_order_swapped
);
   import sbc_pkg::*;

   logic f_valid, f_ready, q_valid, q_ready;
   job_type f_job, q_job;
   result_type res;

   // Front end: per-axis distances and classification.
   sbc_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .center_x(req_center_x), .center_y(req_center_y), .center_z(req_center_z),
      .radius(req_radius),
      .box_min_x(req_box_min_x), .box_min_y(req_box_min_y),
      .box_min_z(req_box_min_z),
      .box_max_x(req_box_max_x), .box_max_y(req_box_max_y),
      .box_max_z(req_box_max_z),
      .sphere_mass_zero(req_sphere_mass_zero),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
   );

   // The queue lets the front end keep taking transfers while the back end stalls, until it fills.
   sbc_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(f_valid), .push_ready(f_ready), .push_data(f_job),
      .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_job)
   );

   sbc_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
      .res_valid(rsp_valid), .res_ready(rsp_ready), .res(res)
   );

   assign rsp_hit = res.hit;
   assign rsp_depth = res.depth;
   assign rsp_normal_x = res.normal_x;
   assign rsp_normal_y = res.normal_y;
   assign rsp_normal_z = res.normal_z;
   assign rsp_order_swapped = res.order_swapped;
endmodule

// File: rtl/core/sbc_checker.sv
`include "assert_macros.svh"

module sbc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_hit,
   input logic [sbc_pkg::RAD_BITS-1:0] rsp_depth,
   input logic signed [sbc_pkg::NORM_BITS-1:0] rsp_normal_x,
   input logic signed [sbc_pkg::NORM_BITS-1:0] rsp_normal_y,
   input logic signed [sbc_pkg::NORM_BITS-1:0] rsp_normal_z,
   input logic rsp_order_swapped
);
   `ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_hit,
      rsp_depth == '0 && rsp_normal_x == '0 && rsp_normal_y == '0 &&
      rsp_normal_z == '0 && !rsp_order_swapped)
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_depth))
   `ASSERT_IMP(a_swap_hit, clock, reset, rsp_valid && rsp_order_swapped, rsp_hit)
endmodule

bind sphere_box_contact sbc_checker u_sbc_checker (.*);

// File: sim/sphere_box_contact_tb.sv
`timescale 1ns / 100ps

module sphere_box_contact_tb;
   import sbc_pkg::*;

   // One sphere and box pair as it crosses the request channel.
   typedef struct {
      logic signed [COORD_BITS-1:0] ctr [3];
      logic signed [COORD_BITS-1:0] lo [3];
      logic signed [COORD_BITS-1:0] hi [3];
      logic [RAD_BITS-1:0] rad;
      logic mass_zero;
   } pair_type;

   // Predicts the contact for each accepted pair and checks results in order.
   class contact_scoreboard;
      result_type pending_q[$];
      int mismatches;
      int checked;
      int hits;
      int face_hits;

      // Rounded integer square root, ties rounding up.
      function automatic longint unsigned root_round(longint unsigned v);
         longint unsigned res = 0;
         longint unsigned bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         if (v > res) res++;
         return res;
      endfunction

      function automatic result_type contact(pair_type p);
         result_type res;
         longint c [3];
         longint l [3];
         longint h [3];
         longint d [3];
         longint unsigned mag [3];
         longint unsigned r = longint'(p.rad);
         longint unsigned dsq = 0;
         longint unsigned dround;
         longint unsigned q;
         longint best = 0;
         longint dl;
         longint dh;
         longint m;
         longint n [3];
         int axis = 0;
         bit minface = 1;
         bit in_box = 1;
         bit near_all = 1;
         res = '0;
         n = '{0, 0, 0};
         for (int i = 0; i < 3; i++) begin
            c[i] = longint'(p.ctr[i]);
            l[i] = longint'(p.lo[i]);
            h[i] = longint'(p.hi[i]);
            if (!(c[i] >= l[i] && c[i] <= h[i])) in_box = 0;
         end
         if (in_box) begin
            for (int i = 0; i < 3; i++) begin
               dl = c[i] - l[i];
               dh = h[i] - c[i];
               m = (dl <= dh) ? dl : dh;
               if (i == 0 || m < best) begin
                  best = m;
                  axis = i;
                  minface = (dl <= dh);
               end
            end
            if (longint'(best) < longint'(r)) begin
               res.hit = 1;
               res.depth = RAD_BITS'(r - best);
               n[axis] = minface ? -(64'sd1 <<< NORMAL_FRAC_BITS)
                                 : (64'sd1 <<< NORMAL_FRAC_BITS);
               face_hits++;
            end
         end else begin
            for (int i = 0; i < 3; i++) begin
               if (c[i] < l[i]) d[i] = c[i] - l[i];
               else if (c[i] > h[i]) d[i] = c[i] - h[i];
               else d[i] = 0;
               mag[i] = (d[i] < 0) ? -d[i] : d[i];
               if (mag[i] > r) near_all = 0;
            end
            if (near_all) begin
               for (int i = 0; i < 3; i++) dsq += mag[i] * mag[i];
               if (dsq <= r * r) begin
                  dround = root_round(dsq);
                  if (dround == 0) dround = 1;
                  res.hit = 1;
                  res.depth = (dround < r) ? RAD_BITS'(r - dround) : '0;
                  for (int i = 0; i < 3; i++) begin
                     q = ((mag[i] << NORMAL_FRAC_BITS) + dround / 2) / dround;
                     if (q > (64'd1 << NORMAL_FRAC_BITS)) q = 64'd1 << NORMAL_FRAC_BITS;
                     n[i] = (d[i] > 0) ? -longint'(q) : longint'(q);
                  end
               end
            end
         end
         res.normal_x = NORM_BITS'(n[0]);
         res.normal_y = NORM_BITS'(n[1]);
         res.normal_z = NORM_BITS'(n[2]);
         res.order_swapped = res.hit & p.mass_zero;
         if (res.hit) hits++;
         return res;
      endfunction

      function void note_pair(pair_type p);
         pending_q.push_back(contact(p));
      endfunction

      function void check_result(result_type act);
         result_type exp;
         checked++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer %p", act);
            return;
         end
         exp = pending_q.pop_front();
         if (act.hit !== exp.hit || act.depth !== exp.depth ||
             act.normal_x !== exp.normal_x || act.normal_y !== exp.normal_y ||
             act.normal_z !== exp.normal_z ||
             act.order_swapped !== exp.order_swapped) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch on result %0d: expected %p, got %p", checked, exp, act);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [COORD_BITS-1:0] req_center_x = 0, req_center_y = 0, req_center_z = 0;
   logic [RAD_BITS-1:0] req_radius = 0;
   logic signed [COORD_BITS-1:0] req_box_min_x = 0, req_box_min_y = 0, req_box_min_z = 0;
   logic signed [COORD_BITS-1:0] req_box_max_x = 0, req_box_max_y = 0, req_box_max_z = 0;
   logic req_sphere_mass_zero = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_hit;
   logic [RAD_BITS-1:0] rsp_depth;
   logic signed [NORM_BITS-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_order_swapped;

   contact_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int sent = 0;
   int cycles = 0;
   localparam int CYCLE_LIMIT = 400000;

   sphere_box_contact dut (.*);

   always #6 clock = ~clock;

   // The receiver stalls at random with the probability of the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Monitors for both channels. Outputs are read before the edge updates them.
   always @(posedge clock) begin
      pair_type p;
      if (!reset && req_valid && req_ready) begin
         p.ctr = '{req_center_x, req_center_y, req_center_z};
         p.lo = '{req_box_min_x, req_box_min_y, req_box_min_z};
         p.hi = '{req_box_max_x, req_box_max_y, req_box_max_z};
         p.rad = req_radius;
         p.mass_zero = req_sphere_mass_zero;
         sb.note_pair(p);
      end
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result('{rsp_hit, rsp_depth, rsp_normal_x, rsp_normal_y,
                           rsp_normal_z, rsp_order_swapped});
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycles, sb.pending_q.size());
         $display("[sphere_box_contact] ERROR");
         $finish;
      end
   end

   function automatic pair_type make_pair(int cx, int cy, int cz, int r,
                                          int lx, int ly, int lz,
                                          int hx, int hy, int hz, bit mz);
      pair_type p;
      p.ctr = '{cx, cy, cz};
      p.lo = '{lx, ly, lz};
      p.hi = '{hx, hy, hz};
      p.rad = RAD_BITS'(r);
      p.mass_zero = mz;
      return p;
   endfunction

   // Random pair. Most are boxes of random scale with the sphere placed close
   // to them, so both the face and the corner paths see real contacts; the
   // rest are raw noise over the full field ranges.
   function automatic pair_type random_pair();
      pair_type p;
      int sh;
      longint base;
      longint ext;
      longint off;
      p.mass_zero = $urandom_range(0, 1);
      if ($urandom_range(0, 99) < 15) begin
         for (int i = 0; i < 3; i++) begin
            p.ctr[i] = $urandom;
            p.lo[i] = $urandom;
            p.hi[i] = $urandom;
         end
         p.rad = RAD_BITS'($urandom);
         return p;
      end
      sh = $urandom_range(1, 29);
      for (int i = 0; i < 3; i++) begin
         base = longint'(int'($urandom)) >>> $urandom_range(1, 30);
         ext = $urandom_range(0, 99) < 5 ? -longint'($urandom_range(1, 8))
                                         : longint'($urandom) % (64'sd1 << sh);
         off = (longint'($urandom) % (64'sd3 << sh)) - (64'sd1 << sh);
         p.lo[i] = COORD_BITS'(base);
         p.hi[i] = COORD_BITS'(base + ext);
         p.ctr[i] = COORD_BITS'(base + off);
      end
      p.rad = RAD_BITS'(longint'($urandom) % (64'sd2 << sh));
      return p;
   endfunction

   // Offers one pair, with an optional idle gap first, and returns once the
   // transfer has happened. Valid is never lowered and raised in one step.
   task automatic push_pair(pair_type p);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_center_x <= p.ctr[0];
      req_center_y <= p.ctr[1];
      req_center_z <= p.ctr[2];
      req_box_min_x <= p.lo[0];
      req_box_min_y <= p.lo[1];
      req_box_min_z <= p.lo[2];
      req_box_max_x <= p.hi[0];
      req_box_max_y <= p.hi[1];
      req_box_max_z <= p.hi[2];
      req_radius <= p.rad;
      req_sphere_mass_zero <= p.mass_zero;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic drain_results();
      req_valid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
   endtask

   localparam int ONE = 32'sh10000;
   localparam int MAXC = 32'h7fffffff;
   localparam int MINC = 32'h80000000;

   initial begin
      pair_type directed [$];
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Center inside a cube, all six faces equally near: x min face wins.
      directed.push_back(make_pair(0, 0, 0, 20, -10, -10, -10, 10, 10, 10, 0));
      // Nearest face ties between y and z only: y wins, here the max face.
      directed.push_back(make_pair(0, 5, 5, 9, -20, -10, -10, 20, 10, 10, 1));
      // Nearest face is z max.
      directed.push_back(make_pair(0, 0, 8, 5, -10, -10, -10, 10, 10, 10, 1));
      // Inside, but the nearest face is exactly one radius away: no contact.
      directed.push_back(make_pair(0, 0, 0, 10, -10, -10, -10, 10, 10, 10, 1));
      // Outside and just touching: depth zero but a hit.
      directed.push_back(make_pair(5, 0, 0, 2, -3, -3, -3, 3, 3, 3, 1));
      // Outside past one LSB of reach.
      directed.push_back(make_pair(6, 0, 0, 2, -3, -3, -3, 3, 3, 3, 0));
      // Corner contact with a diagonal normal.
      directed.push_back(make_pair(4 * ONE, 4 * ONE, 4 * ONE, 2 * ONE,
                                   -3 * ONE, -3 * ONE, -3 * ONE,
                                   3 * ONE, 3 * ONE, 3 * ONE, 0));
      directed.push_back(make_pair(-4 * ONE, 3 * ONE, -5 * ONE, 3 * ONE,
                                   -3 * ONE, -3 * ONE, -3 * ONE,
                                   3 * ONE, 3 * ONE, 3 * ONE, 1));
      // Zero radius, inside and on the surface.
      directed.push_back(make_pair(0, 0, 0, 0, -10, -10, -10, 10, 10, 10, 1));
      directed.push_back(make_pair(10, 0, 0, 0, -10, -10, -10, 10, 10, 10, 1));
      // Inverted box on x, center between the bounds, and a degenerate point box.
      directed.push_back(make_pair(0, 0, 0, 100, 10, -10, -10, -10, 10, 10, 0));
      directed.push_back(make_pair(1, 1, 1, 5, 0, 0, 0, 0, 0, 0, 1));
      directed.push_back(make_pair(0, 0, 0, 5, 0, 0, 0, 0, 0, 0, 1));
      // Coordinate extremes and the largest radius.
      directed.push_back(make_pair(MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC,
                                   MAXC, MAXC, MAXC, 1));
      directed.push_back(make_pair(MINC, MINC, MINC, MAXC, MINC, MINC, MINC,
                                   MAXC, MAXC, MAXC, 0));
      directed.push_back(make_pair(MAXC, MINC, MAXC, MAXC, MINC, MAXC, MINC,
                                   MINC, MAXC, MINC, 1));
      directed.push_back(make_pair(MINC, 0, 0, MAXC, MAXC, 0, 0, MAXC, 0, 0, 0));
      directed.push_back(make_pair(MAXC, 0, 0, MAXC, MINC, 0, 0, MINC, 0, 0, 1));
      directed.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 1));
      foreach (directed[k]) push_pair(directed[k]);

      // Hold the sender off until every directed result has come back.
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         repeat (383) push_pair(random_pair());
      end
      req_valid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("ran %0d pairs through four idle and stall mixes: %0d contacts, %0d on a face",
               sent, sb.hits, sb.face_hits);
      $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("[sphere_box_contact] OK");
      end else begin
         $display("[sphere_box_contact] ERROR");
      end
      $finish;
   end
endmodule
